[rtl/assert_macros.svh]
// ------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers; define ASSERT_OFF to drop them.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// checked only outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
// checked at every edge, reset included
`define ASSERT_CLK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_CLK_RST(lbl, prop, msg)
`endif
`endif

[rtl/fbecho_pkg.sv]
// ------------------------------------------------------------------------
// fbecho_pkg
// Shared constants, register codes and inter-module structs of the echo.
// ------------------------------------------------------------------------
package fbecho_pkg;

  localparam int DELAY_WORDS  = 65536;
  localparam int MAX_CHANNELS = 8;

  localparam int ADDR_W  = $clog2(DELAY_WORDS);
  localparam int LEN_W   = ADDR_W + 1;
  localparam int FP_W    = ADDR_W;
  localparam int CP_W    = $clog2(MAX_CHANNELS);
  localparam int CH_W    = CP_W + 1;
  localparam int STORE_W = 24;
  localparam int PCM_W   = 16;
  localparam int U8_W    = 8;

  localparam int DF_W  = 17;
  localparam int FB_W  = 15;
  localparam int MIX_W = 16;

  localparam int FB_MAX  = 32440;
  localparam int MIX_ONE = 32768;

  // tap dividend: frame * channels + channel, padded to whole radix-4 digits
  localparam int DVD_RAW_W = FP_W + CP_W;
  localparam int DVD_W     = DVD_RAW_W + (DVD_RAW_W % 2);
  localparam int MOD_STEPS = DVD_W / 2;
  localparam int STEP_W    = $clog2(MOD_STEPS);

  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;

  localparam logic FMT_S16 = 1'b0;
  localparam logic FMT_U8  = 1'b1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FORMAT   = 3'd0,
    REG_CHANNELS = 3'd1,
    REG_DELAY    = 3'd2,
    REG_FEEDBACK = 3'd3,
    REG_MIX      = 3'd4
  } reg_idx_t;

  // effective (clipped) configuration
  typedef struct packed {
    logic              fmt;
    logic [CH_W-1:0]   ch;
    logic [LEN_W-1:0]  len;
    logic [FB_W-1:0]   fb;
    logic [MIX_W-1:0]  mix;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
  } mod_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ADDR_W-1:0] rem;
  } mod_rsp_t;

endpackage

[rtl/fbecho_in_if.sv]
// ------------------------------------------------------------------------
// fbecho_in_if
// Sample input channel: valid/ready handshake with one raw PCM word.
// ------------------------------------------------------------------------
interface fbecho_in_if;
  logic                         valid;
  logic                         ready;
  logic [fbecho_pkg::PCM_W-1:0] pcm_in;

  modport source (output valid, output pcm_in, input ready);
  modport sink (input valid, input pcm_in, output ready);
endinterface

[rtl/fbecho_out_if.sv]
// ------------------------------------------------------------------------
// fbecho_out_if
// Result channel: processed PCM word and the channel it belongs to.
// ------------------------------------------------------------------------
interface fbecho_out_if;
  logic                         valid;
  logic                         ready;
  logic [fbecho_pkg::PCM_W-1:0] pcm_out;
  logic [fbecho_pkg::CP_W-1:0]  channel_index;

  modport source (output valid, output pcm_out, output channel_index, input ready);
  modport sink (input valid, input pcm_out, input channel_index, output ready);
endinterface

[rtl/fbecho_ram.sv]
// ------------------------------------------------------------------------
// fbecho_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ------------------------------------------------------------------------
module fbecho_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

[rtl/fbecho_mod.sv]
// ------------------------------------------------------------------------
// fbecho_mod
// Iterative modulo unit: restoring remainder, two dividend bits a cycle.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module fbecho_mod (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fbecho_pkg::mod_req_t         req,
  input  logic [fbecho_pkg::LEN_W-1:0] divisor,
  output fbecho_pkg::mod_rsp_t         rsp
);

  localparam int LEN_W = fbecho_pkg::LEN_W;
  localparam int DVD_W = fbecho_pkg::DVD_W;
  localparam int STEP_W = fbecho_pkg::STEP_W;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;
  logic [LEN_W-1:0]    rem_r, rem_nxt;
  logic [DVD_W-1:0]    dvd_r, dvd_nxt;
  logic [LEN_W-1:0]    div_r, div_nxt;
  logic [LEN_W:0]      sh1_c, sh2_c;
  logic [LEN_W-1:0]    r1_c, r2_c;

  // two restoring steps; the partial remainder stays below the divisor
  always_comb begin
    sh1_c = {rem_r, dvd_r[DVD_W-1]};
    r1_c  = (sh1_c >= {1'b0, div_r}) ? LEN_W'(sh1_c - {1'b0, div_r})
                                     : sh1_c[LEN_W-1:0];
    sh2_c = {r1_c, dvd_r[DVD_W-2]};
    r2_c  = (sh2_c >= {1'b0, div_r}) ? LEN_W'(sh2_c - {1'b0, div_r})
                                     : sh2_c[LEN_W-1:0];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = STEP_W'(fbecho_pkg::MOD_STEPS - 1);
      rem_nxt  = '0;
      dvd_nxt  = req.dividend;
      // hold the divisor for the whole run
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = r2_c;
      dvd_nxt = {dvd_r[DVD_W-3:0], 2'b00};
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.rem  = rem_r[fbecho_pkg::ADDR_W-1:0];

  `ASSERT_CLK(a_mod_rem_below_div, done_r |-> (rem_r < div_r), "remainder not reduced")
  `ASSERT_CLK(a_mod_no_restart, req.start |-> !busy_r, "modulo restarted while busy")

endmodule

[rtl/fbecho_cfg.sv]
// ------------------------------------------------------------------------
// fbecho_cfg
// APB register file; clips the raw settings into the working configuration.
// ------------------------------------------------------------------------
module fbecho_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fbecho_pkg::PADDR_W-1:0] paddr,
  input  logic [fbecho_pkg::PDATA_W-1:0] pwdata,
  output logic [fbecho_pkg::PDATA_W-1:0] prdata,
  output logic                           pready,
  output fbecho_pkg::cfg_t               cfg
);

  localparam int CH_W   = fbecho_pkg::CH_W;
  localparam int DF_W   = fbecho_pkg::DF_W;
  localparam int FB_W   = fbecho_pkg::FB_W;
  localparam int MIX_W  = fbecho_pkg::MIX_W;
  localparam int LEN_W  = fbecho_pkg::LEN_W;
  localparam int PROD_W = DF_W + CH_W;

  logic                         fmt_r;
  logic [CH_W-1:0]              chn_r;
  logic [DF_W-1:0]              df_r;
  logic [FB_W-1:0]              fb_r;
  logic [MIX_W-1:0]             mix_r;
  logic                         wr_en;
  fbecho_pkg::reg_idx_t         idx;
  logic [CH_W-1:0]              ch_eff;
  logic [DF_W-1:0]              df_eff;
  logic [PROD_W-1:0]            len_prod;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = fbecho_pkg::reg_idx_t'(paddr[fbecho_pkg::PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= fbecho_pkg::FMT_S16;
      chn_r <= CH_W'(1);
      df_r  <= DF_W'(1);
      fb_r  <= '0;
      mix_r <= '0;
    end else if (wr_en) begin
      case (idx)
        fbecho_pkg::REG_FORMAT:   fmt_r <= pwdata[0];
        fbecho_pkg::REG_CHANNELS: chn_r <= pwdata[CH_W-1:0];
        fbecho_pkg::REG_DELAY:    df_r  <= pwdata[DF_W-1:0];
        fbecho_pkg::REG_FEEDBACK: fb_r  <= pwdata[FB_W-1:0];
        fbecho_pkg::REG_MIX:      mix_r <= pwdata[MIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      fbecho_pkg::REG_FORMAT:   prdata = fbecho_pkg::PDATA_W'(fmt_r);
      fbecho_pkg::REG_CHANNELS: prdata = fbecho_pkg::PDATA_W'(chn_r);
      fbecho_pkg::REG_DELAY:    prdata = fbecho_pkg::PDATA_W'(df_r);
      fbecho_pkg::REG_FEEDBACK: prdata = fbecho_pkg::PDATA_W'(fb_r);
      fbecho_pkg::REG_MIX:      prdata = fbecho_pkg::PDATA_W'(mix_r);
      default:                  prdata = '0;
    endcase
  end

  // zero channels counts as one, too many saturates
  always_comb begin
    if (chn_r == '0) begin
      ch_eff = CH_W'(1);
    end else if (chn_r > CH_W'(fbecho_pkg::MAX_CHANNELS)) begin
      ch_eff = CH_W'(fbecho_pkg::MAX_CHANNELS);
    end else begin
      ch_eff = chn_r;
    end
    df_eff   = (df_r == '0) ? DF_W'(1) : df_r;
    len_prod = PROD_W'(df_eff) * PROD_W'(ch_eff);
  end

  assign cfg.fmt = fmt_r;
  assign cfg.ch  = ch_eff;
  assign cfg.len = (len_prod > PROD_W'(fbecho_pkg::DELAY_WORDS))
                   ? LEN_W'(fbecho_pkg::DELAY_WORDS) : len_prod[LEN_W-1:0];
  assign cfg.fb  = (fb_r > FB_W'(fbecho_pkg::FB_MAX)) ? FB_W'(fbecho_pkg::FB_MAX) : fb_r;
  assign cfg.mix = (mix_r > MIX_W'(fbecho_pkg::MIX_ONE)) ? MIX_W'(fbecho_pkg::MIX_ONE)
                                                         : mix_r;

endmodule

[rtl/feedback_echo_pcm.sv]
// ------------------------------------------------------------------------
// feedback_echo_pcm
// Each accepted input beat runs the 10-step tap modulo unit (two bits a cycle),
//   one read-modify-write of the delay RAM and the multiply, sum and scale states;
//   no new beat is taken until its result is loaded into the output register. A
//   frame end that finds the frame position past the length adds a modulo run.
// Reset: synchronous, active low; a clearing pass then zeroes all 65536 RAM
//   words while input beats are refused; registers stay writable.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module feedback_echo_pcm (
  input  logic                           clk,
  input  logic                           rst_n,
  fbecho_in_if.sink                      in_ch,
  fbecho_out_if.source                   out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fbecho_pkg::PADDR_W-1:0] paddr,
  input  logic [fbecho_pkg::PDATA_W-1:0] pwdata,
  output logic [fbecho_pkg::PDATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int ADDR_W  = fbecho_pkg::ADDR_W;
  localparam int LEN_W   = fbecho_pkg::LEN_W;
  localparam int FP_W    = fbecho_pkg::FP_W;
  localparam int CP_W    = fbecho_pkg::CP_W;
  localparam int CH_W    = fbecho_pkg::CH_W;
  localparam int DVD_W   = fbecho_pkg::DVD_W;
  localparam int STORE_W = fbecho_pkg::STORE_W;
  localparam int PCM_W   = fbecho_pkg::PCM_W;
  localparam int U8_W    = fbecho_pkg::U8_W;
  localparam int FB_W    = fbecho_pkg::FB_W;
  localparam int MIX_W   = fbecho_pkg::MIX_W;

  localparam int Q_SH   = (PCM_W - 1) + (MIX_W - 1);
  localparam int PFB_W  = STORE_W + FB_W;
  localparam int PDRY_W = 2 * PCM_W;
  localparam int PWET_W = STORE_W + MIX_W;
  localparam int YS_W   = PWET_W + 1;
  localparam int Y_W    = Q_SH + 2;
  localparam int K_W    = PCM_W;
  localparam int T_W    = Y_W + K_W - 1;
  localparam int K_S16  = 32767;
  localparam int K_U8   = 127;

  localparam logic signed [YS_W-1:0] Y_HI = YS_W'(1 << Q_SH);
  localparam logic signed [YS_W-1:0] Y_LO = -Y_HI;

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_DIV   = 9'b000000100,
    ST_READ  = 9'b000001000,
    ST_MUL   = 9'b000010000,
    ST_SUM   = 9'b000100000,
    ST_SCALE = 9'b001000000,
    ST_DONE  = 9'b010000000,
    ST_FMOD  = 9'b100000000
  } state_t;

  fbecho_pkg::cfg_t     cfg;
  fbecho_pkg::mod_req_t mod_req;
  fbecho_pkg::mod_rsp_t mod_rsp;

  state_t                     state_r, state_nxt;
  logic [ADDR_W-1:0]          clr_addr_r, clr_addr_nxt;
  logic [FP_W-1:0]            fp_r, fp_nxt;
  logic [CP_W-1:0]            cp_r, cp_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [PCM_W-1:0]           out_pcm_r;
  logic [CP_W-1:0]            out_chan_r;
  logic [ADDR_W-1:0]          tap_r;
  logic [CP_W-1:0]            chan_r;
  logic signed [PCM_W-1:0]    dry_r, dry_c;
  logic signed [PFB_W-1:0]    p_fb_r;
  logic signed [PDRY_W-1:0]   p_dry_r;
  logic signed [PWET_W-1:0]   p_wet_r;
  logic signed [STORE_W-1:0]  st_r;
  logic signed [Y_W-1:0]      y_r;
  logic signed [T_W-1:0]      t_r;

  logic                       in_acc, out_free, out_load, last_ch_c;
  logic [LEN_W-1:0]           fp_inc_c;
  logic                       ram_we, ram_re;
  logic [ADDR_W-1:0]          ram_waddr;
  logic [STORE_W-1:0]         ram_wdata, ram_rdata;
  logic signed [STORE_W-1:0]  wet_c, fbs_c;
  logic signed [FB_W:0]       fb_s_c;
  logic signed [MIX_W:0]      mix_s_c, dry_gain_c;
  logic signed [STORE_W:0]    st_sum_c;
  logic signed [STORE_W-1:0]  st_sat_c;
  logic signed [YS_W-1:0]     y_sum_c, y_clamp_c;
  logic signed [K_W-1:0]      k_c;
  logic signed [T_W-1:0]      t_bias_c;
  logic [PCM_W-1:0]           q16_c, pcm_c;
  logic [U8_W-1:0]            q8_c;

  fbecho_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fbecho_mod u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mod_req),
    .divisor (cfg.len),
    .rsp     (mod_rsp)
  );

  fbecho_ram #(
    .WIDTH (STORE_W),
    .DEPTH (fbecho_pkg::DELAY_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (tap_r),
    .rdata (ram_rdata)
  );

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign in_acc               = in_ch.valid && in_ch.ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.pcm_out       = out_pcm_r;
  assign out_ch.channel_index = out_chan_r;
  assign out_free             = !out_valid_r || out_ch.ready;

  assign last_ch_c = (({1'b0, cp_r} + CH_W'(1)) >= cfg.ch);
  assign fp_inc_c  = {1'b0, fp_r} + LEN_W'(1);

  // ---------------- control ----------------
  always_comb begin
    state_nxt        = state_r;
    clr_addr_nxt     = clr_addr_r;
    fp_nxt           = fp_r;
    cp_nxt           = cp_r;
    mod_req.start    = 1'b0;
    mod_req.dividend = DVD_W'(fp_r) * DVD_W'(cfg.ch) + DVD_W'(cp_r);
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    ram_waddr        = tap_r;
    ram_wdata        = st_r;
    out_load         = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          mod_req.start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (mod_rsp.done) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        ram_re    = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL:   state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_SCALE;
      ST_SCALE: begin
        ram_we    = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // hold the finished sample until the output register frees up
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
          if (last_ch_c) begin
            cp_nxt = '0;
            if (fp_inc_c < cfg.len) begin
              fp_nxt = fp_inc_c[FP_W-1:0];
            end else if (fp_inc_c == cfg.len) begin
              fp_nxt = '0;
            end else begin
              // position left beyond a shortened delay: reduce it properly
              mod_req.start    = 1'b1;
              mod_req.dividend = DVD_W'(fp_inc_c);
              state_nxt        = ST_FMOD;
            end
          end else begin
            cp_nxt = cp_r + CP_W'(1);
          end
        end
      end
      ST_FMOD: begin
        if (mod_rsp.done) begin
          fp_nxt    = mod_rsp.rem;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      fp_r        <= '0;
      cp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      fp_r        <= fp_nxt;
      cp_r        <= cp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------- datapath ----------------
  // offset bytes become (byte - 128) * 256
  assign dry_c = (cfg.fmt == fbecho_pkg::FMT_U8)
                 ? {~in_ch.pcm_in[U8_W-1], in_ch.pcm_in[U8_W-2:0], {U8_W{1'b0}}}
                 : in_ch.pcm_in;

  assign wet_c      = ram_rdata;
  assign fb_s_c     = {1'b0, cfg.fb};
  assign mix_s_c    = {1'b0, cfg.mix};
  assign dry_gain_c = (MIX_W + 1)'(fbecho_pkg::MIX_ONE) - mix_s_c;

  // floor of wet * gain / 2^15 is the top slice of the product
  assign fbs_c    = p_fb_r[PFB_W-1:FB_W];
  assign st_sum_c = (STORE_W + 1)'(dry_r) + (STORE_W + 1)'(fbs_c);
  assign st_sat_c = (st_sum_c[STORE_W] != st_sum_c[STORE_W-1])
                    ? {st_sum_c[STORE_W], {(STORE_W - 1){~st_sum_c[STORE_W]}}}
                    : st_sum_c[STORE_W-1:0];

  assign y_sum_c = YS_W'(p_dry_r) + YS_W'(p_wet_r);
  always_comb begin
    if (y_sum_c > Y_HI) begin
      y_clamp_c = Y_HI;
    end else if (y_sum_c < Y_LO) begin
      y_clamp_c = Y_LO;
    end else begin
      y_clamp_c = y_sum_c;
    end
  end

  assign k_c = (cfg.fmt == fbecho_pkg::FMT_U8) ? K_W'(K_U8) : K_W'(K_S16);

  // 16-bit: truncate toward zero; 8-bit: floor and re-offset
  assign t_bias_c = t_r + (t_r[T_W-1] ? T_W'((1 << Q_SH) - 1) : T_W'(0));
  assign q16_c    = t_bias_c[Q_SH +: PCM_W];
  assign q8_c     = t_r[Q_SH +: U8_W] + U8_W'(128);
  assign pcm_c    = (cfg.fmt == fbecho_pkg::FMT_U8) ? PCM_W'(q8_c) : q16_c;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      dry_r  <= dry_c;
      chan_r <= cp_r;
    end
    if (state_r == ST_DIV && mod_rsp.done) begin
      tap_r <= mod_rsp.rem;
    end
    if (state_r == ST_MUL) begin
      p_fb_r  <= PFB_W'(wet_c) * PFB_W'(fb_s_c);
      p_dry_r <= PDRY_W'(dry_r) * PDRY_W'(dry_gain_c);
      p_wet_r <= PWET_W'(wet_c) * PWET_W'(mix_s_c);
    end
    if (state_r == ST_SUM) begin
      st_r <= st_sat_c;
      y_r  <= Y_W'(y_clamp_c);
    end
    if (state_r == ST_SCALE) begin
      t_r <= T_W'(y_r) * T_W'(k_c);
    end
    if (out_load) begin
      out_pcm_r  <= pcm_c;
      out_chan_r <= chan_r;
    end
  end

  `ASSERT_CLK_RST(a_reset_enters_clear, !rst_n |=> (state_r == ST_CLEAR), "no clearing pass after reset")
  `ASSERT_CLK(a_mod_done_waited, mod_rsp.done |-> (state_r == ST_DIV || state_r == ST_FMOD), "modulo result with nobody waiting")
  `ASSERT_CLK(a_accept_mod_idle, in_acc |-> !mod_rsp.busy, "beat accepted while modulo unit busy")

endmodule

[tb/sv/feedback_echo_pcm_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// feedback_echo_pcm_tb
// Drives PCM beats through the feedback echo and checks every result beat
// field by field against an in-bench fixed-point echo predictor with its own
// delay store, frame and channel counters. A directed script comes first:
// the extremes of both formats, clamping and saturating register values,
// unlisted register indexes and a channel count change mid-frame. Random
// phases with fresh register settings and varied idling on both channels
// follow, one of them with a long output hold-off.
// ----------------------------------------------------------------------------
module feedback_echo_pcm_tb;

  localparam int STORE_W      = fbecho_pkg::STORE_W;
  localparam int REG_IDX_W    = fbecho_pkg::REG_IDX_W;
  localparam int PCM_W        = fbecho_pkg::PCM_W;
  localparam int U8_W         = fbecho_pkg::U8_W;
  localparam int CP_W         = fbecho_pkg::CP_W;
  localparam int CH_W         = fbecho_pkg::CH_W;
  localparam int DF_W         = fbecho_pkg::DF_W;
  localparam int FB_W         = fbecho_pkg::FB_W;
  localparam int MIX_W        = fbecho_pkg::MIX_W;
  localparam int PADDR_W      = fbecho_pkg::PADDR_W;
  localparam int PDATA_W      = fbecho_pkg::PDATA_W;
  localparam int DELAY_WORDS  = fbecho_pkg::DELAY_WORDS;
  localparam int MAX_CHANNELS = fbecho_pkg::MAX_CHANNELS;
  localparam int FB_MAX       = fbecho_pkg::FB_MAX;
  localparam int MIX_ONE      = fbecho_pkg::MIX_ONE;

  localparam int HALF_NS      = 6;
  localparam int RESET_CYCLES = 5;
  localparam int WATCHDOG_NS  = 30_000_000;
  localparam int ECHO_LATENCY = 16;
  localparam int TAIL_CYCLES  = 2 * ECHO_LATENCY + 11;
  localparam int ECHO_PHASES  = 9;
  localparam int PHASE_BEATS  = 81;
  localparam int HOLD_PHASE   = 6;
  localparam int HOLD_CYCLES  = 300;
  localparam int STORE_TOP    = (1 << (STORE_W - 1)) - 1;
  localparam int STORE_BOTTOM = -(1 << (STORE_W - 1));
  localparam longint Q30_ONE  = 64'sd1 << 30;

  // indexes past the register list, writes there must change nothing
  localparam logic [REG_IDX_W-1:0] REG_HOLE_LO = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_HOLE_HI = 3'd7;
  // register field is ignored on beat rows
  localparam logic [REG_IDX_W-1:0] SEL_NONE    = '0;

  localparam logic [PCM_W-1:0] EDGE_WORDS [6] = '{
    16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h00FF, 16'h0080
  };

  typedef struct packed {
    logic [PCM_W-1:0] pcm_out;
    logic [CP_W-1:0]  channel_index;
  } echo_result_t;

  typedef struct packed {
    bit               given;
    logic [PCM_W-1:0] pcm_out;
  } pcm_hint_t;

  typedef enum logic {ROW_BEAT, ROW_WRITE} script_op_t;

  typedef struct packed {
    script_op_t           op;
    logic [REG_IDX_W-1:0] sel;
    logic [PDATA_W-1:0]   value;
    bit                   given;
    logic [PCM_W-1:0]     pcm_out;
  } script_row_t;

  localparam int SCRIPT_ROWS = 38;
  localparam script_row_t ECHO_SCRIPT [SCRIPT_ROWS] = '{
    // reset settings: dry path only, 16-bit
    '{ROW_BEAT,  SEL_NONE,                 32'h0000_7FFF, 1'b1, 16'h7FFE},
    '{ROW_BEAT,  SEL_NONE,                 32'h0000_8000, 1'b1, 16'h8001},
    '{ROW_BEAT,  SEL_NONE,                 32'h0000_0000, 1'b1, 16'h0000},
    '{ROW_BEAT,  SEL_NONE,                 32'h0000_FFFF, 1'b1, 16'h0000},
    '{ROW_BEAT,  SEL_NONE,                 32'h0000_4000, 1'b1, 16'h3FFF},
    // feedback above its ceiling, fully wet
    '{ROW_WRITE, fbecho_pkg::REG_FEEDBACK, 32'd32767,     1'b0, 16'h0000},
    '{ROW_WRITE, fbecho_pkg::REG_MIX,      32'd32768,     1'b0, 16'h0000},
    '{ROW_BEAT,  SEL_NONE,                 32'h0000_1234, 1'b0, 16'h0000},
    '{ROW_BEAT,  SEL_NONE,                 32'h0000_8000, 1'b0, 16'h0000},
    '{ROW_BEAT,  SEL_NONE,                 32'h0000_7FFF, 1'b0, 16'h0000},
    // offset 8-bit, dry only; upper byte ignored
    '{ROW_WRITE, fbecho_pkg::REG_FORMAT,   32'd1,         1'b0, 16'h0000},
    '{ROW_WRITE, fbecho_pkg::REG_MIX,      32'd0,         1'b0, 16'h0000},
    '{ROW_WRITE, fbecho_pkg::REG_FEEDBACK, 32'd0,         1'b0, 16'h0000},
    '{ROW_BEAT,  SEL_NONE,                 32'h0000_00FF, 1'b1, 16'h00FE},
    '{ROW_BEAT,  SEL_NONE,                 32'h0000_0000, 1'b1, 16'h0001},
    '{ROW_BEAT,  SEL_NONE,                 32'h0000_FF80, 1'b1, 16'h0080},
    // zero channels, mix above one
    '{ROW_WRITE, fbecho_pkg::REG_CHANNELS, 32'd0,         1'b0, 16'h0000},
    '{ROW_WRITE, fbecho_pkg::REG_MIX,      32'd65535,     1'b0, 16'h0000},
    '{ROW_BEAT,  SEL_NONE,                 32'h0000_00A5, 1'b0, 16'h0000},
    // channels above the maximum, zero delay
    '{ROW_WRITE, fbecho_pkg::REG_CHANNELS, 32'd15,        1'b0, 16'h0000},
    '{ROW_WRITE, fbecho_pkg::REG_DELAY,    32'd0,         1'b0, 16'h0000},
    '{ROW_WRITE, fbecho_pkg::REG_FEEDBACK, 32'd16384,     1'b0, 16'h0000},
    '{ROW_BEAT,  SEL_NONE,                 32'h0000_0011, 1'b0, 16'h0000},
    '{ROW_BEAT,  SEL_NONE,                 32'h0000_00EE, 1'b0, 16'h0000},
    '{ROW_BEAT,  SEL_NONE,                 32'h0000_0000, 1'b0, 16'h0000},
    '{ROW_BEAT,  SEL_NONE,                 32'h0000_00FF, 1'b0, 16'h0000},
    '{ROW_BEAT,  SEL_NONE,                 32'h0000_0080, 1'b0, 16'h0000},
    // shrink the frame while the channel position sits past the new count
    '{ROW_WRITE, fbecho_pkg::REG_CHANNELS, 32'd3,         1'b0, 16'h0000},
    '{ROW_BEAT,  SEL_NONE,                 32'h0000_0042, 1'b0, 16'h0000},
    '{ROW_BEAT,  SEL_NONE,                 32'h0000_00C0, 1'b0, 16'h0000},
    // longest delay, clipped to the store
    '{ROW_WRITE, fbecho_pkg::REG_DELAY,    32'd131071,    1'b0, 16'h0000},
    '{ROW_WRITE, REG_HOLE_LO,              32'hFFFF_FFFF, 1'b0, 16'h0000},
    '{ROW_WRITE, REG_HOLE_HI,              32'hFFFF_FFFF, 1'b0, 16'h0000},
    '{ROW_BEAT,  SEL_NONE,                 32'h0000_0001, 1'b0, 16'h0000},
    '{ROW_BEAT,  SEL_NONE,                 32'h0000_00FE, 1'b0, 16'h0000},
    '{ROW_WRITE, fbecho_pkg::REG_FORMAT,   32'd0,         1'b0, 16'h0000},
    '{ROW_BEAT,  SEL_NONE,                 32'h0000_7FFF, 1'b0, 16'h0000},
    '{ROW_BEAT,  SEL_NONE,                 32'h0000_8000, 1'b0, 16'h0000}
  };

  logic               clk = 1'b0;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  fbecho_in_if  in_bus ();
  fbecho_out_if out_bus ();

  feedback_echo_pcm u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state and register copies
  bit signed [STORE_W-1:0] echo_store [DELAY_WORDS];
  int unsigned             frame_pos = 0;
  int unsigned             chan_pos  = 0;
  logic                    sh_format   = fbecho_pkg::FMT_S16;
  logic [CH_W-1:0]         sh_channels = 1;
  logic [DF_W-1:0]         sh_delay    = 1;
  logic [FB_W-1:0]         sh_feedback = 0;
  logic [MIX_W-1:0]        sh_mix      = 0;

  echo_result_t pending_echo_q [$];
  pcm_hint_t    pcm_hint_q [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          recv_hold_req = 1'b0;
  int unsigned fail_count    = 0;
  int unsigned checked_beats = 0;
  int unsigned reg_writes    = 0;

  always begin
    #HALF_NS clk = 1'b1;
    #HALF_NS clk = 1'b0;
  end

  function automatic echo_result_t predict_echo_sample(input logic [PCM_W-1:0] raw);
    int unsigned  chans;
    int unsigned  span;
    int unsigned  tap;
    longint       fb;
    longint       mix;
    longint       dry;
    longint       wet;
    longint       st;
    longint       y;
    longint       t;
    longint       q;
    echo_result_t res;
    chans = (sh_channels == 0) ? 1 :
            (sh_channels > MAX_CHANNELS) ? MAX_CHANNELS : sh_channels;
    span = ((sh_delay == 0) ? 1 : sh_delay) * chans;
    if (span > DELAY_WORDS) span = DELAY_WORDS;
    fb  = (sh_feedback > FB_MAX) ? FB_MAX : sh_feedback;
    mix = (sh_mix > MIX_ONE) ? MIX_ONE : sh_mix;
    if (sh_format == fbecho_pkg::FMT_S16) dry = longint'($signed(raw));
    else dry = (longint'(raw[U8_W-1:0]) - 128) * 256;

    tap = (frame_pos * chans + chan_pos) % span;
    wet = longint'(echo_store[tap]);
    st  = dry + ((wet * fb) >>> 15);
    if (st > STORE_TOP) st = STORE_TOP;
    if (st < STORE_BOTTOM) st = STORE_BOTTOM;
    echo_store[tap] = st[STORE_W-1:0];

    y = dry * (MIX_ONE - mix) + wet * mix;
    if (y > Q30_ONE) y = Q30_ONE;
    if (y < -Q30_ONE) y = -Q30_ONE;
    if (sh_format == fbecho_pkg::FMT_S16) begin
      // truncate toward zero
      t = y * 32767;
      q = (t >= 0) ? (t >>> 30) : -((-t) >>> 30);
      res.pcm_out = q[PCM_W-1:0];
    end else begin
      t = y * 127 + (longint'(128) <<< 30);
      q = t >>> 30;
      res.pcm_out = PCM_W'(q[U8_W-1:0]);
    end
    res.channel_index = chan_pos[CP_W-1:0];

    if (chan_pos + 1 >= chans) begin
      chan_pos  = 0;
      frame_pos = (frame_pos + 1) % span;
    end else begin
      chan_pos++;
    end
    return res;
  endfunction

  // offer one beat; valid is left high so back-to-back beats need no toggle
  task automatic offer_pcm_sample(input logic [PCM_W-1:0] word, input bit given,
                                  input logic [PCM_W-1:0] typed_out);
    if ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    pcm_hint_q.push_back('{given: given, pcm_out: typed_out});
    in_bus.valid  <= 1'b1;
    in_bus.pcm_in <= word;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic drain_echo();
    in_bus.valid <= 1'b0;
    while (pending_echo_q.size() != 0 || pcm_hint_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_echo_reg(input logic [REG_IDX_W-1:0] sel,
                                input logic [PDATA_W-1:0] val);
    logic [PDATA_W-1:0]   kept;
    bit                   listed;
    fbecho_pkg::reg_idx_t reg_code;
    listed   = 1'b1;
    reg_code = fbecho_pkg::reg_idx_t'(sel);
    case (sel)
      fbecho_pkg::REG_FORMAT: begin
        kept = PDATA_W'(val[0]);
        sh_format = val[0];
      end
      fbecho_pkg::REG_CHANNELS: begin
        kept = PDATA_W'(val[CH_W-1:0]);
        sh_channels = val[CH_W-1:0];
      end
      fbecho_pkg::REG_DELAY: begin
        kept = PDATA_W'(val[DF_W-1:0]);
        sh_delay = val[DF_W-1:0];
      end
      fbecho_pkg::REG_FEEDBACK: begin
        kept = PDATA_W'(val[FB_W-1:0]);
        sh_feedback = val[FB_W-1:0];
      end
      fbecho_pkg::REG_MIX: begin
        kept = PDATA_W'(val[MIX_W-1:0]);
        sh_mix = val[MIX_W-1:0];
      end
      default: begin
        kept   = '0;
        listed = 1'b0;
      end
    endcase
    reg_writes++;

    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);

    if (listed) begin
      // read back through a second transfer, psel held
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (prdata !== kept) begin
        $error("%s readback: expected %h, got %h", reg_code.name(), kept, prdata);
        fail_count++;
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // idle with psel low so the next transfer opens on a fresh edge
    @(posedge clk);
  endtask

  // predict on every input beat, check every result beat
  always @(posedge clk) begin : echo_monitor
    pcm_hint_t    hint;
    echo_result_t want;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        hint = (pcm_hint_q.size() != 0) ? pcm_hint_q.pop_front() : '0;
        want = predict_echo_sample(in_bus.pcm_in);
        if (hint.given) want.pcm_out = hint.pcm_out;
        pending_echo_q.push_back(want);
      end
      if (out_bus.valid && out_bus.ready) begin
        if (pending_echo_q.size() == 0) begin
          $error("result beat with nothing pending: pcm_out %h, channel_index %0d",
                 out_bus.pcm_out, out_bus.channel_index);
          fail_count++;
        end else begin
          want = pending_echo_q.pop_front();
          checked_beats++;
          if (out_bus.pcm_out !== want.pcm_out) begin
            $error("pcm_out: expected %h, got %h", want.pcm_out, out_bus.pcm_out);
            fail_count++;
          end
          if (out_bus.channel_index !== want.channel_index) begin
            $error("channel_index: expected %0d, got %0d",
                   want.channel_index, out_bus.channel_index);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin : result_sink
    int unsigned held;
    held = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (recv_hold_req) begin
        out_bus.ready <= 1'b0;
        held++;
        if (held == HOLD_CYCLES) begin
          held = 0;
          recv_hold_req = 1'b0;
        end
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [PCM_W-1:0] word;
    int unsigned      pick;
    logic [DF_W-1:0]  delay_v;
    rst_n         = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.pcm_in = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // first beat waits out the store clearing pass
    for (int r = 0; r < SCRIPT_ROWS; r++) begin
      if (ECHO_SCRIPT[r].op == ROW_WRITE) begin
        drain_echo();
        write_echo_reg(ECHO_SCRIPT[r].sel, ECHO_SCRIPT[r].value);
      end else begin
        offer_pcm_sample(ECHO_SCRIPT[r].value[PCM_W-1:0], ECHO_SCRIPT[r].given,
                         ECHO_SCRIPT[r].pcm_out);
      end
    end

    for (int ph = 0; ph < ECHO_PHASES; ph++) begin
      drain_echo();
      // counters and store carry over; only the settings change
      write_echo_reg(fbecho_pkg::REG_FORMAT, PDATA_W'($urandom_range(1)));
      write_echo_reg(fbecho_pkg::REG_CHANNELS, PDATA_W'(($urandom_range(7) == 0) ?
                     $urandom_range(15) : $urandom_range(1, MAX_CHANNELS)));
      pick = $urandom_range(9);
      if (pick < 5) delay_v = DF_W'($urandom_range(8));
      else if (pick < 8) delay_v = DF_W'($urandom_range(9, 400));
      else delay_v = DF_W'($urandom_range((1 << DF_W) - 1));
      write_echo_reg(fbecho_pkg::REG_DELAY, PDATA_W'(delay_v));
      write_echo_reg(fbecho_pkg::REG_FEEDBACK, PDATA_W'(($urandom_range(3) == 0) ?
                     $urandom_range((1 << FB_W) - 1, FB_MAX) : $urandom_range(FB_MAX)));
      write_echo_reg(fbecho_pkg::REG_MIX, PDATA_W'(($urandom_range(3) == 0) ?
                     $urandom_range((1 << MIX_W) - 1) : $urandom_range(MIX_ONE)));

      if (ph < 3) begin
        send_idle_pct = 38;
        recv_idle_pct = 60;
      end else if (ph < 6) begin
        send_idle_pct = 60;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // block the result side while beats keep coming
      if (ph == HOLD_PHASE) recv_hold_req = 1'b1;

      for (int n = 0; n < PHASE_BEATS; n++) begin
        if ($urandom_range(7) == 0) word = EDGE_WORDS[$urandom_range(5)];
        else word = PCM_W'($urandom());
        offer_pcm_sample(word, 1'b0, '0);
      end
    end

    drain_echo();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d result beats across %0d register writes,", checked_beats,
             reg_writes);
    $display("both sample formats, clipped settings and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
